FILE: rtl/rslp_pkg.sv
// rslp_pkg: shared types, constants and the CORDIC arctangent table for the pinwheel block.
// No dependencies; used by rslp_regs, rslp_ctrl, rslp_dp and rotating_spoke_led_pattern.
package rslp_pkg;

	localparam int MAX_STEPS = 24;
	localparam int ITER_W    = 5;
	localparam int XY_W      = 28;
	localparam int Z_W       = 22;
	localparam int APB_AW    = 5;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_SPIN_STEP  = 3'd0;
	localparam logic [2:0] REG_HALF_WIDTH = 3'd1;
	localparam logic [2:0] REG_HUE_STEP   = 3'd2;
	localparam logic [2:0] REG_CENTRE_X   = 3'd3;
	localparam logic [2:0] REG_CENTRE_Y   = 3'd4;
	localparam logic [2:0] REG_LEVEL      = 3'd5;

	localparam logic [15:0] RST_SPIN_STEP  = 16'd1043;
	localparam logic [15:0] RST_HALF_WIDTH = 16'd10430;
	localparam logic [15:0] RST_HUE_STEP   = 16'd1311;
	localparam logic [4:0]  RST_LEVEL      = 5'd12;

	localparam logic [15:0] PHASE_033 = 16'd21627;
	localparam logic [15:0] PHASE_066 = 16'd43254;
	localparam logic [15:0] SPOKE_1   = 16'd21845;
	localparam logic [15:0] SPOKE_2   = 16'd43691;
	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

	// angles in 1/2^20 turn
	localparam logic signed [Z_W-1:0] TURN_HALF    = 22'sd524288;
	localparam logic signed [Z_W-1:0] TURN_QUARTER = 22'sd262144;
	localparam logic signed [Z_W-1:0] TURN_FULL    = 22'sd1048576;

	// 128*65536 + 32768: offset plus rounding for the colour scale
	localparam logic signed [35:0] COLOUR_BIAS = 36'sd8421376;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] led_x;
		logic signed [15:0] led_y;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [4:0] level;
		logic       lit;
	} res_t;

	typedef struct packed {
		logic [15:0]        spin_step;
		logic [15:0]        half_width;
		logic [15:0]        hue_step;
		logic signed [15:0] centre_x;
		logic signed [15:0] centre_y;
		logic [4:0]         level;
	} cfg_t;

	typedef struct packed {
		logic              capture_tick;
		logic              capture_pix;
		logic              sine_load;
		logic              step;
		logic              colour_wr;
		logic              fin;
		logic              out_load;
		logic [1:0]        sel;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	function automatic logic [17:0] atan_q20(input logic [ITER_W-1:0] i);
		logic [17:0] a;
		case (i)
			5'd0:  a = 18'd131072;
			5'd1:  a = 18'd77376;
			5'd2:  a = 18'd40884;
			5'd3:  a = 18'd20753;
			5'd4:  a = 18'd10417;
			5'd5:  a = 18'd5213;
			5'd6:  a = 18'd2607;
			5'd7:  a = 18'd1304;
			5'd8:  a = 18'd652;
			5'd9:  a = 18'd326;
			5'd10: a = 18'd163;
			5'd11: a = 18'd81;
			5'd12: a = 18'd41;
			5'd13: a = 18'd20;
			5'd14: a = 18'd10;
			5'd15: a = 18'd5;
			5'd16: a = 18'd3;
			5'd17: a = 18'd1;
			5'd18: a = 18'd1;
			default: a = 18'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/rslp_regs.sv
// rslp_regs: APB-style configuration register file for the pinwheel block.
// Depends on rslp_pkg (cfg_t, register indexes, reset values).
module rslp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rslp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output rslp_pkg::cfg_t               cfg
);

	rslp_pkg::cfg_t cfg_q;
	logic           wr;
	logic [2:0]     idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spin_step  <= rslp_pkg::RST_SPIN_STEP;
			cfg_q.half_width <= rslp_pkg::RST_HALF_WIDTH;
			cfg_q.hue_step   <= rslp_pkg::RST_HUE_STEP;
			cfg_q.centre_x   <= '0;
			cfg_q.centre_y   <= '0;
			cfg_q.level      <= rslp_pkg::RST_LEVEL;
		end else if (wr) begin
			case (idx)
				rslp_pkg::REG_SPIN_STEP:  cfg_q.spin_step  <= pwdata[15:0];
				rslp_pkg::REG_HALF_WIDTH: cfg_q.half_width <= pwdata[15:0];
				rslp_pkg::REG_HUE_STEP:   cfg_q.hue_step   <= pwdata[15:0];
				rslp_pkg::REG_CENTRE_X:   cfg_q.centre_x   <= pwdata[15:0];
				rslp_pkg::REG_CENTRE_Y:   cfg_q.centre_y   <= pwdata[15:0];
				rslp_pkg::REG_LEVEL:      cfg_q.level      <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rslp_pkg::REG_SPIN_STEP:  prdata = {16'd0, cfg_q.spin_step};
			rslp_pkg::REG_HALF_WIDTH: prdata = {16'd0, cfg_q.half_width};
			rslp_pkg::REG_HUE_STEP:   prdata = {16'd0, cfg_q.hue_step};
			rslp_pkg::REG_CENTRE_X:   prdata = {16'd0, cfg_q.centre_x};
			rslp_pkg::REG_CENTRE_Y:   prdata = {16'd0, cfg_q.centre_y};
			rslp_pkg::REG_LEVEL:      prdata = {27'd0, cfg_q.level};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/rslp_ctrl.sv
// rslp_ctrl: sequencer for the pinwheel block; drives the datapath through cmd_t.
// Depends on rslp_pkg (cmd_t, ITER_W).
module rslp_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_mode,
	input  logic           res_busy,
	output logic           item_stall,
	output rslp_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SLOAD = 3'd1;
	localparam logic [2:0] ST_SITER = 3'd2;
	localparam logic [2:0] ST_SCOL  = 3'd3;
	localparam logic [2:0] ST_PITER = 3'd4;
	localparam logic [2:0] ST_PFIN  = 3'd5;
	localparam logic [2:0] ST_POUT  = 3'd6;

	localparam logic [rslp_pkg::ITER_W-1:0] LAST = rslp_pkg::ITER_W'(CORDIC_STEPS - 1);

	logic [2:0]                  state_q, state_d;
	logic [1:0]                  sel_q, sel_d;
	logic [rslp_pkg::ITER_W-1:0] iter_q, iter_d;

	// reset lands in the colour sequence so the frame colour is built before first use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SLOAD;
			sel_q   <= 2'd0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		iter_d  = iter_q;
		cmd     = '0;
		cmd.sel  = sel_q;
		cmd.iter = iter_q;
		case (state_q)
			ST_IDLE: begin
				iter_d = '0;
				sel_d  = 2'd0;
				if (item_valid) begin
					if (item_mode) begin
						cmd.capture_pix = 1'b1;
						state_d = ST_PITER;
					end else begin
						cmd.capture_tick = 1'b1;
						state_d = ST_SLOAD;
					end
				end
			end
			ST_SLOAD: begin
				cmd.sine_load = 1'b1;
				iter_d  = '0;
				state_d = ST_SITER;
			end
			ST_SITER: begin
				cmd.step = 1'b1;
				iter_d   = iter_q + 1'b1;
				if (iter_q == LAST) state_d = ST_SCOL;
			end
			ST_SCOL: begin
				cmd.colour_wr = 1'b1;
				if (sel_q == 2'd2) begin
					state_d = ST_IDLE;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = ST_SLOAD;
				end
			end
			ST_PITER: begin
				cmd.step = 1'b1;
				iter_d   = iter_q + 1'b1;
				if (iter_q == LAST) state_d = ST_PFIN;
			end
			ST_PFIN: begin
				cmd.fin = 1'b1;
				state_d = ST_POUT;
			end
			ST_POUT: begin
				if (!res_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

FILE: rtl/rslp_dp.sv
// rslp_dp: datapath with animation state, frame colour and one shared CORDIC unit
// (rotation for sine, vectoring for atan2). Depends on rslp_pkg.
module rslp_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  rslp_pkg::cmd_t  cmd,
	input  rslp_pkg::item_t item,
	input  rslp_pkg::cfg_t  cfg,
	input  logic            res_stall,
	output logic            res_valid,
	output rslp_pkg::res_t  res
);

	localparam int XW = rslp_pkg::XY_W;
	localparam int ZW = rslp_pkg::Z_W;

	logic [15:0]          spin_q, hue_q;
	logic [7:0]           fr_q, fg_q, fb_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 vec_q, zero_q;
	logic [15:0]          rel_q;
	rslp_pkg::res_t       res_q;
	logic                 res_valid_q;

	// pixel setup: offset from centre, Q8.8 -> Q12.16, left half plane folded over
	logic signed [16:0]   dx, dy;
	logic signed [XW-1:0] px, py;
	assign dx = $signed({item.led_x[15], item.led_x}) - $signed({cfg.centre_x[15], cfg.centre_x});
	assign dy = $signed({item.led_y[15], item.led_y}) - $signed({cfg.centre_y[15], cfg.centre_y});
	assign px = {{(XW-25){dx[16]}}, dx, 8'd0};
	assign py = {{(XW-25){dy[16]}}, dy, 8'd0};

	// sine setup: phase folded into [-1/4, 1/4] turn
	logic [15:0]          ph;
	logic signed [ZW-1:0] zw, zf;
	always_comb begin
		case (cmd.sel)
			2'd1:    ph = hue_q + rslp_pkg::PHASE_033;
			2'd2:    ph = hue_q + rslp_pkg::PHASE_066;
			default: ph = hue_q;
		endcase
		zw = $signed({2'b00, ph, 4'b0000});
		if (ph[15]) zw = zw - rslp_pkg::TURN_FULL;
		if (zw > rslp_pkg::TURN_QUARTER)
			zf = rslp_pkg::TURN_HALF - zw;
		else if (zw < -rslp_pkg::TURN_QUARTER)
			zf = -rslp_pkg::TURN_HALF - zw;
		else
			zf = zw;
	end

	// one CORDIC micro-rotation
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	logic                 cw;
	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;
	assign at = $signed({{(ZW-18){1'b0}}, rslp_pkg::atan_q20(cmd.iter)});
	assign cw = vec_q ? ~y_q[XW-1] : z_q[ZW-1];

	// colour = clamp((128<<16) + 127*sin + 0.5) >> 16
	logic signed [35:0] ye, v;
	logic [7:0]         col;
	always_comb begin
		ye = 36'(y_q);
		v  = (ye <<< 7) - ye + rslp_pkg::COLOUR_BIAS;
		if (v[35])
			col = 8'd0;
		else if (|v[35:24])
			col = 8'd255;
		else
			col = v[23:16];
	end

	// angle rounding to 1/65536 turn, spin removed
	logic [ZW-1:0] zr;
	logic [15:0]   ang;
	assign zr  = z_q + ZW'(8);
	assign ang = zero_q ? 16'd0 : zr[19:4];

	function automatic logic near(input logic [15:0] r, input logic [15:0] s,
	                              input logic [15:0] hw);
		logic [15:0] d;
		d = r - s;
		if (d > 16'd32768) d = 16'd0 - d;
		return d < hw;
	endfunction

	logic lit;
	assign lit = near(rel_q, 16'd0, cfg.half_width)
	           | near(rel_q, rslp_pkg::SPOKE_1, cfg.half_width)
	           | near(rel_q, rslp_pkg::SPOKE_2, cfg.half_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q <= '0;
			hue_q  <= '0;
		end else if (cmd.capture_tick) begin
			spin_q <= spin_q + cfg.spin_step;
			hue_q  <= hue_q + cfg.hue_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_pix) begin
			vec_q  <= 1'b1;
			zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
			x_q    <= dx[16] ? -px : px;
			y_q    <= dx[16] ? -py : py;
			z_q    <= dx[16] ? rslp_pkg::TURN_HALF : '0;
		end else if (cmd.sine_load) begin
			vec_q <= 1'b0;
			x_q   <= $signed({{(XW-16){1'b0}}, rslp_pkg::INV_GAIN_Q16});
			y_q   <= '0;
			z_q   <= zf;
		end else if (cmd.step) begin
			if (cw) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (cmd.colour_wr) begin
			case (cmd.sel)
				2'd0:    fr_q <= col;
				2'd1:    fg_q <= col;
				default: fb_q <= col;
			endcase
		end
		if (cmd.fin) rel_q <= ang - spin_q;
		if (cmd.out_load) begin
			res_q.red   <= lit ? fr_q : 8'd0;
			res_q.green <= lit ? fg_q : 8'd0;
			res_q.blue  <= lit ? fb_q : 8'd0;
			res_q.level <= cfg.level;
			res_q.lit   <= lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.out_load)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/rotating_spoke_led_pattern.sv
// Pixel transaction: PITER vectors the offset on the shared CORDIC, PFIN registers the angle
//   less the spin, POUT the result; no new item is taken until the FSM is back in IDLE.
// Frame tick: no result; the next item is taken only after three sine evaluations run one
//   after another on the same CORDIC unit (SLOAD, SITER, SCOL for each colour).
// Reset (arst_n low, asynchronous): registers to defaults, angle and phase to zero; then
//   the frame colour is built with item_stall high.
module rotating_spoke_led_pattern #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  rslp_pkg::item_t              item,
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output rslp_pkg::res_t               res,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rslp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	rslp_pkg::cfg_t cfg;
	rslp_pkg::cmd_t cmd;
	logic           res_busy;

	// zero wait-state register port
	assign pready = 1'b1;

	rslp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// a finished pixel waits in POUT only while the previous result is still held
	assign res_busy = res_valid & res_stall;

	rslp_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_mode  (item.mode),
		.res_busy   (res_busy),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// the output register lets a new transaction be taken while a result waits
	rslp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg       (cfg),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	// every accepted transaction starts work, so the port closes in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item port open right after a transaction");

	// a new result only comes out of a pixel sequence, never while idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_stall))
		else $error("result appeared without work in progress");

	// a dark LED carries no colour
	a_dark_black: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.lit) |-> (res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0))
		else $error("unlit pixel with colour");

	// command pulses are mutually exclusive
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture_tick, cmd.capture_pix, cmd.sine_load, cmd.step,
		          cmd.colour_wr, cmd.fin, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule
